### hw/rtl/mac_learning_table_core_defines.svh
// ============================================================================
// mac_learning_table_core assertion macros
// Concurrent check wrappers, compiled out when SYNTHESIS is defined.
// ============================================================================
`ifndef MAC_LEARNING_TABLE_CORE_DEFINES_SVH
`define MAC_LEARNING_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// plain property, checked every clock outside reset
`define MLT_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mac_learning_table_core: assertion failed");
// same-cycle implication
`define MLT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mac_learning_table_core: implication failed");
// next-cycle implication
`define MLT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mac_learning_table_core: next-cycle implication failed");
`else
`define MLT_ASSERT(name, clk, rst_n, prop)
`define MLT_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define MLT_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/mlt_pkg.sv
// ============================================================================
// mlt_pkg
// Shared types and constants of the MAC learning table.
// ============================================================================
`timescale 1ns / 1ps

package mlt_pkg;

    localparam int MAC_W      = 48;
    localparam int STAMP_W    = 32;
    localparam int LIMIT_W    = 7;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 7'd64;
    localparam logic [STAMP_W-1:0] LIFETIME_RESET = 32'd300;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_LIMIT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIFETIME = 1'd1;

    typedef struct packed {
        logic [MAC_W-1:0]   src_mac;
        logic [MAC_W-1:0]   dst_mac;
        logic               in_port;
        logic [STAMP_W-1:0] now;
    } t_item;

    typedef struct packed {
        logic dest_known;
        logic dest_port;
        logic flood;
    } t_result;

    // word that walks the cell chain; lookup selects the pass
    typedef struct packed {
        logic               lookup;
        logic [MAC_W-1:0]   src_mac;
        logic [MAC_W-1:0]   dst_mac;
        logic               port;
        logic [STAMP_W-1:0] now;
        logic               hit;
        logic               have_min;
        logic [STAMP_W-1:0] min_stamp;
        logic               found;
        logic               fwd;
    } t_tok;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEARN,
        ST_LOOKUP
    } t_state;

endpackage

### hw/rtl/mlt_cell.sv
// ============================================================================
// mlt_cell
// One table entry plus one stage of the scan chain.
// ============================================================================
`timescale 1ns / 1ps

module mlt_cell #(
    parameter int TABLE_DEPTH = 64,
    parameter int CELL_IDX    = 0
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]      i_cnt,
    input  logic [mlt_pkg::STAMP_W-1:0]           i_lifetime,
    input  logic                                  i_vld,
    input  mlt_pkg::t_tok                         i_tok,
    input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] i_idx,
    output logic                                  o_vld,
    output mlt_pkg::t_tok                         o_tok,
    output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] o_idx
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(CELL_IDX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    // entry storage
    logic [mlt_pkg::MAC_W-1:0]   r_mac;
    logic                        r_port;
    logic [mlt_pkg::STAMP_W-1:0] r_stamp;

    logic                        r_vld;
    mlt_pkg::t_tok               r_tok;
    logic [IDX_W-1:0]            r_idx;

    mlt_pkg::t_tok               n_tok;
    logic [IDX_W-1:0]            n_idx;
    logic                        wr;
    logic                        active;
    logic [mlt_pkg::MAC_W-1:0]   view_mac;
    logic                        view_port;
    logic [mlt_pkg::STAMP_W-1:0] view_stamp;
    logic [mlt_pkg::STAMP_W-1:0] age;

    always_comb begin
        n_tok      = i_tok;
        n_idx      = i_idx;
        wr         = 1'b0;
        active     = (MY_POS < i_cnt);
        view_mac   = r_mac;
        view_port  = r_port;
        view_stamp = r_stamp;
        if (i_vld && i_tok.lookup) begin
            // write of the learned entry lands here before the lookup sees it
            if (i_idx == MY_IDX) begin
                wr         = 1'b1;
                view_mac   = i_tok.src_mac;
                view_port  = i_tok.port;
                view_stamp = i_tok.now;
            end
        end
        age = i_tok.now - view_stamp;
        if (i_vld && active) begin
            if (!i_tok.lookup) begin
                if (!i_tok.hit) begin
                    if (r_mac == i_tok.src_mac) begin
                        n_tok.hit = 1'b1;
                        n_idx     = MY_IDX;
                    end else if (!i_tok.have_min || (r_stamp < i_tok.min_stamp)) begin
                        n_tok.have_min  = 1'b1;
                        n_tok.min_stamp = r_stamp;
                        n_idx           = MY_IDX;
                    end
                end
            end else begin
                if (!i_tok.found && (view_mac == i_tok.dst_mac) && (age < i_lifetime)) begin
                    n_tok.found = 1'b1;
                    n_tok.fwd   = view_port;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mac   <= i_tok.src_mac;
            r_port  <= i_tok.port;
            r_stamp <= i_tok.now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        r_idx <= n_idx;
    end

    assign o_vld = r_vld;
    assign o_tok = r_tok;
    assign o_idx = r_idx;

endmodule

### hw/rtl/mac_learning_table_core.sv
// ============================================================================
// mac_learning_table_core
// Learning switch address table built as a chain of entry cells.
// ============================================================================
`timescale 1ns / 1ps
// Usage:
//   Input word: pulse start with i_item (src_mac, dst_mac, in_port, now)
//   while busy is low; the word is taken at that clock edge.
//   Result word: o_result (dest_known, dest_port, flood) is valid for exactly
//   one cycle while o_done is high; the receiver cannot stall it.
//   Config: i_cfg_we with i_cfg_idx / i_cfg_wdata writes table_limit (0) or
//   entry_lifetime (1); only while busy is low and no result is pending.
// Timing:
//   Each frame takes two walks of a word through the TABLE_DEPTH cells: a
//   learn pass (source hit / oldest entry search) and a lookup pass that also
//   writes the learned entry at its slot. o_done rises in the same cycle that
//   busy drops; a new word is taken only once the frame before it is done,
//   so the block works on one frame at a time. The chain length sets how
//   long each frame takes.
// Reset:
//   Synchronous, active low: entry count cleared, registers to limit 64 and
//   lifetime 300. Entry contents are not cleared; only slots below the count
//   are ever looked at.
`include "mac_learning_table_core_defines.svh"

module mac_learning_table_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  mlt_pkg::t_item                     i_item,
    output logic                               o_done,
    output mlt_pkg::t_result                   o_result,
    input  logic                               i_cfg_we,
    input  logic [mlt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mlt_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    // width wide enough for both the count and the 7-bit limit register
    localparam int CMP_W = (CNT_W > mlt_pkg::LIMIT_W) ? CNT_W : mlt_pkg::LIMIT_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);

    // config registers
    logic [mlt_pkg::LIMIT_W-1:0] r_limit;
    logic [mlt_pkg::STAMP_W-1:0] r_lifetime;

    // control
    mlt_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_lvld, n_lvld;
    mlt_pkg::t_tok    r_ltok, n_ltok;
    logic [IDX_W-1:0] r_lidx, n_lidx;
    logic             r_o_vld, n_o_vld;
    mlt_pkg::t_result r_res, n_res;

    // chain wiring: element k feeds cell k
    logic                  w_vld [TABLE_DEPTH+1];
    mlt_pkg::t_tok         w_tok [TABLE_DEPTH+1];
    logic [IDX_W-1:0]      w_idx [TABLE_DEPTH+1];
    logic [TABLE_DEPTH:0]  w_all_vld;

    logic [CMP_W-1:0] use_lim;
    logic [CMP_W-1:0] cnt_ext;
    logic             tail_vld;
    mlt_pkg::t_tok    tail_tok;
    logic [IDX_W-1:0] tail_idx;

    assign w_vld[0] = r_lvld;
    assign w_tok[0] = r_ltok;
    assign w_idx[0] = r_lidx;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        mlt_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cnt      (r_count),
            .i_lifetime (r_lifetime),
            .i_vld      (w_vld[g]),
            .i_tok      (w_tok[g]),
            .i_idx      (w_idx[g]),
            .o_vld      (w_vld[g+1]),
            .o_tok      (w_tok[g+1]),
            .o_idx      (w_idx[g+1])
        );
    end

    for (genvar v = 0; v <= TABLE_DEPTH; v++) begin : g_vld
        assign w_all_vld[v] = w_vld[v];
    end

    assign tail_vld = w_vld[TABLE_DEPTH];
    assign tail_tok = w_tok[TABLE_DEPTH];
    assign tail_idx = w_idx[TABLE_DEPTH];

    // limit 0 acts as 1, above depth acts as depth
    always_comb begin
        use_lim = CMP_W'(r_limit);
        if (use_lim == '0) begin
            use_lim = CMP_W'(1);
        end
        if (use_lim > DEPTH_C) begin
            use_lim = DEPTH_C;
        end
        cnt_ext = CMP_W'(r_count);
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= mlt_pkg::LIMIT_RESET;
            r_lifetime <= mlt_pkg::LIFETIME_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mlt_pkg::REG_TABLE_LIMIT: begin
                    r_limit <= i_cfg_wdata[mlt_pkg::LIMIT_W-1:0];
                end
                mlt_pkg::REG_ENTRY_LIFETIME: begin
                    r_lifetime <= i_cfg_wdata[mlt_pkg::STAMP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer: launch learn pass, pick the slot, launch lookup pass, report
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_lvld  = 1'b0;
        n_ltok  = r_ltok;
        n_lidx  = r_lidx;
        n_o_vld = 1'b0;
        n_res   = r_res;
        unique case (r_state)
            mlt_pkg::ST_IDLE: begin
                if (start) begin
                    n_lvld           = 1'b1;
                    n_ltok.lookup    = 1'b0;
                    n_ltok.src_mac   = i_item.src_mac;
                    n_ltok.dst_mac   = i_item.dst_mac;
                    n_ltok.port      = i_item.in_port;
                    n_ltok.now       = i_item.now;
                    n_ltok.hit       = 1'b0;
                    n_ltok.have_min  = 1'b0;
                    n_ltok.min_stamp = '0;
                    n_ltok.found     = 1'b0;
                    n_ltok.fwd       = 1'b0;
                    n_lidx           = '0;
                    n_state          = mlt_pkg::ST_LEARN;
                end
            end
            mlt_pkg::ST_LEARN: begin
                if (tail_vld) begin
                    n_lvld        = 1'b1;
                    n_ltok        = tail_tok;
                    n_ltok.lookup = 1'b1;
                    n_ltok.found  = 1'b0;
                    n_ltok.fwd    = 1'b0;
                    // hit: refresh in place; else append or replace oldest
                    if (tail_tok.hit) begin
                        n_lidx = tail_idx;
                    end else if (cnt_ext < use_lim) begin
                        n_lidx  = r_count[IDX_W-1:0];
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_lidx = tail_idx;
                    end
                    n_state = mlt_pkg::ST_LOOKUP;
                end
            end
            mlt_pkg::ST_LOOKUP: begin
                if (tail_vld) begin
                    n_o_vld          = 1'b1;
                    n_res.dest_known = tail_tok.found;
                    n_res.dest_port  = tail_tok.found & tail_tok.fwd;
                    n_res.flood      = ~tail_tok.found;
                    n_state          = mlt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mlt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlt_pkg::ST_IDLE;
            r_count <= '0;
            r_lvld  <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_lvld  <= n_lvld;
            r_o_vld <= n_o_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ltok <= n_ltok;
        r_lidx <= n_lidx;
        r_res  <= n_res;
    end

    assign busy     = (r_state != mlt_pkg::ST_IDLE);
    assign o_done   = r_o_vld;
    assign o_result = r_res;

    // at most one word in flight along the chain
    `MLT_ASSERT(a_one_word, i_clk, i_rst_n, $countones(w_all_vld) <= 1)
    // entry count never passes the table depth
    `MLT_ASSERT(a_count_max, i_clk, i_rst_n, CMP_W'(r_count) <= DEPTH_C)
    // a word only leaves the chain while a frame is being worked
    `MLT_ASSERT_IMP(a_tail_busy, i_clk, i_rst_n, tail_vld, busy)
    // the result strobe comes with the block free again
    `MLT_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    // an accepted word launches the learn pass
    `MLT_ASSERT_NXT(a_launch, i_clk, i_rst_n, start && !busy, r_lvld && busy)

endmodule

### dv/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for mac_learning_table_core. Words go in on start/busy
// and each frame's forwarding decision is checked against an in-bench model
// of the address table (learn source, then look up destination).
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH      = 64;   // table entries, matches the dut parameter
    localparam int POOL       = 96;   // MACs recycled by the random part, > DEPTH
    localparam int PHASES     = 8;
    localparam int PHASE_WORDS = 150;

    // Slowest legal run: ~1220 words, each with its busy time, gap and handoff,
    // takes about 350 us. Allow well over five times that.
    localparam int TIMEOUT_NS = 2_000_000;

    localparam logic [mlt_pkg::MAC_W-1:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;
    localparam logic [mlt_pkg::MAC_W-1:0] MAC_ZERO = 48'h0000_0000_0000;
    localparam logic [mlt_pkg::MAC_W-1:0] MAC_A    = 48'h0200_0000_000A;
    localparam logic [mlt_pkg::MAC_W-1:0] MAC_C    = 48'h0200_0000_000C;
    localparam logic [mlt_pkg::MAC_W-1:0] MAC_D    = 48'h0200_0000_000D;
    localparam logic [mlt_pkg::MAC_W-1:0] MAC_E    = 48'h0200_0000_000E;
    localparam logic [mlt_pkg::MAC_W-1:0] MAC_F    = 48'h0200_0000_000F;
    localparam logic [mlt_pkg::MAC_W-1:0] MAC_G    = 48'h0200_0000_0010;
    localparam logic [mlt_pkg::MAC_W-1:0] MAC_H    = 48'h0200_0000_0011;

    // directed stimulus row: either a frame word or a register write
    typedef enum logic {
        ROW_FRAME,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind                          kind;
        mlt_pkg::t_item                     frame;
        logic                               typed;    // want holds a hand-written answer
        mlt_pkg::t_result                   want;
        logic [mlt_pkg::CFG_IDX_W-1:0]      reg_idx;
        logic [mlt_pkg::CFG_DATA_W-1:0]     reg_val;
    } t_row;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    mlt_pkg::t_item                     i_item;
    logic                               o_done;
    mlt_pkg::t_result                   o_result;
    logic                               i_cfg_we;
    logic [mlt_pkg::CFG_IDX_W-1:0]      i_cfg_idx;
    logic [mlt_pkg::CFG_DATA_W-1:0]     i_cfg_wdata;

    mac_learning_table_core #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shadow forwarding database. Mirrors the dut's table contents and its
    // two registers; updated at the edge where a word is accepted, which is
    // safe because the dut handles one frame at a time.
    // ------------------------------------------------------------------------
    logic [mlt_pkg::MAC_W-1:0]      fdb_mac   [DEPTH];
    logic                           fdb_port  [DEPTH];
    logic [mlt_pkg::STAMP_W-1:0]    fdb_stamp [DEPTH];
    int unsigned                    fdb_used;
    logic [mlt_pkg::LIMIT_W-1:0]    shadow_limit;
    logic [mlt_pkg::STAMP_W-1:0]    shadow_lifetime;

    mlt_pkg::t_result               pending_fwd [$];   // decisions still owed by the dut
    int                             mismatch_cnt;

    // random-part knobs
    logic [mlt_pkg::MAC_W-1:0]      known_macs [POOL];
    int                             pool_span;
    int                             step_max;
    logic [mlt_pkg::STAMP_W-1:0]    wall_s;

    // Learn the source, then resolve the destination. Returns the decision
    // the dut must produce for this frame.
    function automatic mlt_pkg::t_result forward_decision(input mlt_pkg::t_item f);
        int unsigned                    lim;
        int unsigned                    oldest;
        int unsigned                    slot;
        logic                           hit;
        logic                           found;
        logic [mlt_pkg::STAMP_W-1:0]    age;
        mlt_pkg::t_result               r;
        // limit 0 behaves as 1, anything past the depth as the depth
        lim = shadow_limit;
        if (lim == 0) lim = 1;
        if (lim > DEPTH) lim = DEPTH;

        // source hit refreshes; otherwise track the first smallest stamp
        hit    = 1'b0;
        oldest = 0;
        for (int i = 0; i < fdb_used && !hit; i++) begin
            if (fdb_mac[i] == f.src_mac) begin
                fdb_port[i]  = f.in_port;
                fdb_stamp[i] = f.now;
                hit          = 1'b1;
            end else if (fdb_stamp[i] < fdb_stamp[oldest]) begin
                oldest = i;
            end
        end
        if (!hit) begin
            // a lowered limit never appends; it replaces among all used slots
            if (fdb_used < lim) begin
                slot     = fdb_used;
                fdb_used = fdb_used + 1;
            end else begin
                slot = oldest;
            end
            fdb_mac[slot]   = f.src_mac;
            fdb_port[slot]  = f.in_port;
            fdb_stamp[slot] = f.now;
        end

        // first live match wins; age wraps modulo 2^32
        found = 1'b0;
        r     = '0;
        for (int i = 0; i < fdb_used && !found; i++) begin
            age = f.now - fdb_stamp[i];
            if (age < shadow_lifetime && fdb_mac[i] == f.dst_mac) begin
                found        = 1'b1;
                r.dest_known = 1'b1;
                r.dest_port  = fdb_port[i];
            end
        end
        r.flood = !found;
        return r;
    endfunction

    function automatic logic [mlt_pkg::MAC_W-1:0] any_mac();
        return mlt_pkg::MAC_W'({$urandom, $urandom});
    endfunction

    // Random frame: mostly MACs from a recycled pool so that sources hit,
    // destinations resolve and a full table gets churned; the rest is noise.
    function automatic mlt_pkg::t_item random_frame();
        mlt_pkg::t_item f;
        int             pick;
        pick      = $urandom_range(0, 99);
        f.src_mac = (pick < 85) ? known_macs[$urandom_range(0, pool_span - 1)] : any_mac();
        pick      = $urandom_range(0, 99);
        if (pick < 70)
            f.dst_mac = known_macs[$urandom_range(0, pool_span - 1)];
        else if (pick < 82)
            f.dst_mac = f.src_mac;
        else
            f.dst_mac = any_mac();
        // time mostly creeps forward (ties included), sometimes leaps or wraps
        pick = $urandom_range(0, 99);
        if (pick < 90)
            wall_s = wall_s + $urandom_range(0, step_max);
        else if (pick < 97)
            wall_s = wall_s + $urandom_range(0, 1000);
        else
            wall_s = $urandom;
        f.now     = wall_s;
        f.in_port = 1'($urandom_range(0, 1));
        return f;
    endfunction

    function automatic t_row frame_row(input logic [mlt_pkg::MAC_W-1:0] src,
                                       input logic [mlt_pkg::MAC_W-1:0] dst,
                                       input logic port,
                                       input logic [mlt_pkg::STAMP_W-1:0] stamp,
                                       input logic typed,
                                       input mlt_pkg::t_result want);
        t_row r;
        r               = '0;
        r.kind          = ROW_FRAME;
        r.frame.src_mac = src;
        r.frame.dst_mac = dst;
        r.frame.in_port = port;
        r.frame.now     = stamp;
        r.typed         = typed;
        r.want          = want;
        return r;
    endfunction

    function automatic t_row write_row(input logic [mlt_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [mlt_pkg::CFG_DATA_W-1:0] val);
        t_row r;
        r         = '0;
        r.kind    = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side. Everything is driven at the falling edge; start stays
    // high across back-to-back words so it never gets two NBAs in one step.
    // ------------------------------------------------------------------------

    // Present one word and hold it until the dut takes it (start & !busy).
    task automatic send_frame(input mlt_pkg::t_item f, input logic typed,
                              input mlt_pkg::t_result want);
        mlt_pkg::t_result guess;
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= f;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        guess = forward_decision(f);
        pending_fwd.push_back(typed ? want : guess);
    endtask

    // Hold start low before the next word; n sets how long, and 0 skips the idle.
    task automatic idle_sender(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Stop sending and wait for every owed decision; the dut is idle after.
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_fwd.size() != 0 || busy) @(posedge i_clk);
    endtask

    // Register writes only happen with the dut idle.
    task automatic write_reg(input logic [mlt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mlt_pkg::CFG_DATA_W-1:0] val);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == mlt_pkg::REG_TABLE_LIMIT)
            shadow_limit = val[mlt_pkg::LIMIT_W-1:0];   // upper data bits are dropped
        else if (idx == mlt_pkg::REG_ENTRY_LIFETIME)
            shadow_lifetime = val;
    endtask

    // ------------------------------------------------------------------------
    // Result checker. o_done lasts one cycle and cannot be held off, so every
    // strobe is consumed at the rising edge that ends it.
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string what, input logic exp_v, input logic got_v);
        if (mismatch_cnt < 10)
            $display("%0t: %s expected %b got %b", $realtime, what, exp_v, got_v);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        mlt_pkg::t_result want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_fwd.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("%0t: result word with nothing outstanding: %b",
                             $realtime, o_result);
                mismatch_cnt++;
            end else begin
                want = pending_fwd.pop_front();
                if (o_result.dest_known !== want.dest_known)
                    note_mismatch("dest_known", want.dest_known, o_result.dest_known);
                if (o_result.dest_port !== want.dest_port)
                    note_mismatch("dest_port", want.dest_port, o_result.dest_port);
                if (o_result.flood !== want.flood)
                    note_mismatch("flood", want.flood, o_result.flood);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        t_row                               stim_rows [$];
        int                                 phase_limit [PHASES];
        logic [mlt_pkg::STAMP_W-1:0]        phase_life  [PHASES];
        logic [mlt_pkg::CFG_DATA_W-1:0]     lim_word;
        logic [mlt_pkg::STAMP_W-1:0]        life;
        int                                 gap;
        logic                               idle_on;

        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_item          = '0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_wdata     = '0;
        mismatch_cnt    = 0;
        fdb_used        = 0;
        shadow_limit    = mlt_pkg::LIMIT_RESET;
        shadow_lifetime = mlt_pkg::LIFETIME_RESET;
        for (int i = 0; i < DEPTH; i++) begin
            fdb_mac[i]   = '0;
            fdb_port[i]  = 1'b0;
            fdb_stamp[i] = '0;
        end

        // Directed part. Typed answers are {dest_known, dest_port, flood}.
        // Limit of zero: one slot only, the second MAC evicts the first.
        stim_rows.push_back(write_row(mlt_pkg::REG_TABLE_LIMIT, 32'd0));
        stim_rows.push_back(frame_row(MAC_A, MAC_A, 1'b1, 32'd100, 1'b1, 3'b110));
        stim_rows.push_back(frame_row(MAC_ONES, MAC_A, 1'b0, 32'd150, 1'b1, 3'b001));
        // limit above depth acts as the depth
        stim_rows.push_back(write_row(mlt_pkg::REG_TABLE_LIMIT, 32'd127));
        stim_rows.push_back(frame_row(MAC_A, MAC_A, 1'b1, 32'd200, 1'b1, 3'b110));
        // stamp at the top of the range, then age across the wrap
        stim_rows.push_back(frame_row(MAC_ONES, MAC_ZERO, 1'b0, 32'hFFFF_FFFF, 1'b1, 3'b001));
        stim_rows.push_back(frame_row(MAC_ZERO, MAC_ONES, 1'b1, 32'd0, 1'b1, 3'b100));
        // age equal to the lifetime is dead; the expired entry is refreshed
        stim_rows.push_back(frame_row(MAC_C, MAC_A, 1'b0, 32'd500, 1'b1, 3'b001));
        stim_rows.push_back(frame_row(MAC_A, MAC_A, 1'b0, 32'd500, 1'b1, 3'b100));
        // zero lifetime floods even a fresh self-lookup
        stim_rows.push_back(write_row(mlt_pkg::REG_ENTRY_LIFETIME, 32'd0));
        stim_rows.push_back(frame_row(MAC_D, MAC_D, 1'b1, 32'd600, 1'b1, 3'b001));
        stim_rows.push_back(write_row(mlt_pkg::REG_ENTRY_LIFETIME, 32'hFFFF_FFFF));
        stim_rows.push_back(frame_row(MAC_E, MAC_C, 1'b1, 32'd700, 1'b1, 3'b100));
        // limit lowered below the count: replacement among all six in use
        stim_rows.push_back(write_row(mlt_pkg::REG_TABLE_LIMIT, 32'd3));
        stim_rows.push_back(frame_row(MAC_F, MAC_ONES, 1'b1, 32'd900, 1'b0, '0));
        stim_rows.push_back(frame_row(MAC_ZERO, MAC_F, 1'b0, 32'd901, 1'b0, '0));
        // lifetime of one: only an entry stamped this very second is live
        stim_rows.push_back(write_row(mlt_pkg::REG_TABLE_LIMIT, 32'd64));
        stim_rows.push_back(write_row(mlt_pkg::REG_ENTRY_LIFETIME, 32'd1));
        stim_rows.push_back(frame_row(MAC_G, MAC_F, 1'b0, 32'd901, 1'b1, 3'b001));
        stim_rows.push_back(frame_row(MAC_H, MAC_H, 1'b1, 32'd1000, 1'b1, 3'b110));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[r]) begin
            if (stim_rows[r].kind == ROW_WRITE)
                write_reg(stim_rows[r].reg_idx, stim_rows[r].reg_val);
            else
                send_frame(stim_rows[r].frame, stim_rows[r].typed, stim_rows[r].want);
        end

        // Random part: phases of register settings, each with its own pool
        // span so both a sparse table and a full, churning table are hit.
        known_macs[0] = MAC_ZERO;
        known_macs[1] = MAC_ONES;
        for (int i = 2; i < POOL; i++) known_macs[i] = any_mac();
        phase_limit = '{8, 1, 0, 40, 64, 127, 100, 0};
        phase_life  = '{32'd300, 32'd0, 32'hFFFF_FFFF, 32'd1,
                        32'd50, 32'd300, 32'd1000, 32'd0};
        wall_s = 32'd2000;

        for (int p = 0; p < PHASES; p++) begin
            lim_word = phase_limit[p];
            life     = phase_life[p];
            if (p == PHASES - 1) begin
                // junk in the unused data bits must not reach the limit
                lim_word = ($urandom & 32'hFFFF_FF80) | $urandom_range(0, 127);
                life     = $urandom_range(1, 2000);
            end
            write_reg(mlt_pkg::REG_TABLE_LIMIT, lim_word);
            write_reg(mlt_pkg::REG_ENTRY_LIFETIME, life);

            pool_span = (p % 2 == 0) ? $urandom_range(4, 16) : $urandom_range(64, POOL);
            step_max  = (life == 0 || life > 400) ? 40 : life / 6 + 1;
            idle_on   = (p % 3 != 1);      // some phases run back to back
            if (p == 3) wall_s = 32'hFFFF_FF00;   // walk time across the wrap

            for (int n = 0; n < PHASE_WORDS; n++) begin
                gap = idle_on ? $urandom_range(0, 10) : 0;
                // now and then let the table go quiet before the next word
                if ($urandom_range(0, 24) == 0) drain_results();
                idle_sender(gap);
                send_frame(random_frame(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (2 * DEPTH + 10) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_fwd.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
